/* rtl/touch_swipe_and_double_tap_wake_defines.svh */
// Assertion macros shared by the touch wake gesture block.
`ifndef TOUCH_SWIPE_AND_DOUBLE_TAP_WAKE_DEFINES_SVH
`define TOUCH_SWIPE_AND_DOUBLE_TAP_WAKE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSWK_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tswk assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TSWK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tswk assertion failed");

`endif

/* rtl/tswk_pkg.sv */
`default_nettype none
package tswk_pkg;

  localparam int PANEL_WIDTH_DEF = 1080;
  localparam int TIME_BITS_DEF   = 32;

  localparam int POS_BITS  = 11;
  localparam int TICK_BITS = 32;
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  localparam int SW_T1       = 25;
  localparam int SW_T2       = 50;
  localparam int SW_T3       = 75;
  localparam int TAP_SPAN    = 800;
  localparam int TAP_MIN_GAP = 10;
  localparam int TAP_WINDOW  = 80;
  localparam int TAP_DELTA   = 75;
  localparam int TAP_LO      = 120;
  localparam int TAP_Y_HI    = 1800;
  localparam int TAP_X_HI    = 960;

  localparam logic CMD_SWIPE = 1'b0;
  localparam logic CMD_TAP   = 1'b1;

  typedef enum logic [2:0] {
    REG_SWEEP_MODE   = 3'd0,
    REG_TAP_ENABLE   = 3'd1,
    REG_POCKET_CHECK = 3'd2,
    REG_START_POS    = 3'd3,
    REG_MID_POS      = 3'd4,
    REG_END_POS      = 3'd5,
    REG_HEIGHT_SPLIT = 3'd6,
    REG_SWAP_AXES    = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STAGE_IDLE  = 2'd0,
    STAGE_ONE   = 2'd1,
    STAGE_TWO   = 2'd2,
    STAGE_THREE = 2'd3
  } stage_t;

  typedef struct packed {
    logic [1:0]          sweep_mode;
    logic                tap_enable;
    logic                pocket_check_enable;
    logic [POS_BITS-1:0] start_pos;
    logic [POS_BITS-1:0] mid_pos;
    logic [POS_BITS-1:0] end_pos;
    logic [POS_BITS-1:0] height_split;
    logic                swap_axes;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sweep_mode:          2'd2,
    tap_enable:          1'b1,
    pocket_check_enable: 1'b1,
    start_pos:           11'd100,
    mid_pos:             11'd270,
    end_pos:             11'd540,
    height_split:        11'd100,
    swap_axes:           1'b0
  };

  typedef struct packed {
    logic                 cmd;
    logic [POS_BITS-1:0]  x_pos;
    logic [POS_BITS-1:0]  y_pos;
    logic [TICK_BITS-1:0] tick_time;
    logic [3:0]           finger_count;
    logic                 screen_off;
    logic                 pocket_clear;
  } in_item_t;

  typedef struct packed {
    logic power_press;
    logic gesture_seen;
  } out_item_t;

  typedef struct packed {
    logic go;
    logic multi;
  } ctl_t;

endpackage
`default_nettype wire

/* rtl/touch_swipe_and_double_tap_wake.sv */
// Touch wake gesture detector: swipe to wake or sleep, and double tap to wake.
// Touch samples come in on the in_valid/in_stall channel, one sample per
// transfer, and every sample gives exactly one result on the out_valid/out_stall
// channel: power_press and gesture_seen, both low when no gesture completed.
// A sample taken at one clock edge lands in the input register, is evaluated
// against the tracker state while it sits there and then loads into the result
// register, from which its result transfers.
// With no stall a new sample is taken every cycle; the tracker state is updated
// in the same cycle the result register loads, so consecutive samples see each
// other with no gap.
// When the receiver stalls, the result register holds; the input register fills
// and in_stall rises only once both stages hold an item.
// Reset empties both stages, clears all sweep and tap tracking, and loads the
// configuration defaults. Registers are at APB byte address 4*i; pready is always
// high. The user must make writes only while the block idles; nothing enforces it.
`default_nettype none
`include "touch_swipe_and_double_tap_wake_defines.svh"
module touch_swipe_and_double_tap_wake
  import tswk_pkg::*;
#(
  parameter int PANEL_WIDTH = PANEL_WIDTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  cfg_t                 cfg;
  logic                 s1_valid;
  in_item_t             s1_item;
  logic                 advance;
  logic [TIME_BITS-1:0] t;
  logic                 sweep_fire, tap_fire, fire, blocked;
  ctl_t                 ctl;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign t        = TIME_BITS'(s1_item.tick_time);

  assign ctl = '{go: s1_valid && advance, multi: s1_item.finger_count > 4'd1};

  assign fire    = sweep_fire || tap_fire;
  assign blocked = s1_item.screen_off && cfg.pocket_check_enable && !s1_item.pocket_clear;

  tswk_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tswk_sweep #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .TIME_BITS   (TIME_BITS)
  ) u_sweep (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .other_fire (tap_fire),
    .item       (s1_item),
    .cfg        (cfg),
    .t          (t),
    .fire       (sweep_fire)
  );

  tswk_tap #(
    .TIME_BITS (TIME_BITS)
  ) u_tap (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .other_fire (sweep_fire),
    .item       (s1_item),
    .cfg        (cfg),
    .t          (t),
    .fire       (tap_fire)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      out_data.power_press  <= fire && !blocked;
      out_data.gesture_seen <= fire;
    end
  end

  `TSWK_ASSERT_NOW(a_stall_when_full, clk, rst, in_stall, s1_valid && out_valid && out_stall)
  `TSWK_ASSERT_NOW(a_one_source, clk, rst, sweep_fire, !tap_fire)
  `TSWK_ASSERT_NEXT(a_fire_reported, clk, rst, fire, out_valid && out_data.gesture_seen)
  `TSWK_ASSERT_NOW(a_press_is_gesture, clk, rst, out_valid && out_data.power_press,
                   out_data.gesture_seen)

endmodule
`default_nettype wire

/* rtl/tswk_cfg_regs.sv */
`default_nettype none
module tswk_cfg_regs
  import tswk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  cfg_reg_e reg_sel;

  assign reg_sel = cfg_reg_e'(paddr[ADDR_BITS-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_SWEEP_MODE:   cfg.sweep_mode <= pwdata[1:0];
        REG_TAP_ENABLE:   cfg.tap_enable <= pwdata[0];
        REG_POCKET_CHECK: cfg.pocket_check_enable <= pwdata[0];
        REG_START_POS:    cfg.start_pos <= pwdata[POS_BITS-1:0];
        REG_MID_POS:      cfg.mid_pos <= pwdata[POS_BITS-1:0];
        REG_END_POS:      cfg.end_pos <= pwdata[POS_BITS-1:0];
        REG_HEIGHT_SPLIT: cfg.height_split <= pwdata[POS_BITS-1:0];
        REG_SWAP_AXES:    cfg.swap_axes <= pwdata[0];
        default:          cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_SWEEP_MODE:   prdata = {30'd0, cfg.sweep_mode};
      REG_TAP_ENABLE:   prdata = {31'd0, cfg.tap_enable};
      REG_POCKET_CHECK: prdata = {31'd0, cfg.pocket_check_enable};
      REG_START_POS:    prdata = {21'd0, cfg.start_pos};
      REG_MID_POS:      prdata = {21'd0, cfg.mid_pos};
      REG_END_POS:      prdata = {21'd0, cfg.end_pos};
      REG_HEIGHT_SPLIT: prdata = {21'd0, cfg.height_split};
      REG_SWAP_AXES:    prdata = {31'd0, cfg.swap_axes};
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/tswk_sweep.sv */
`default_nettype none
module tswk_sweep
  import tswk_pkg::*;
#(
  parameter int PANEL_WIDTH = PANEL_WIDTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_t                 ctl,
  input  logic                 other_fire,
  input  in_item_t             item,
  input  cfg_t                 cfg,
  input  logic [TIME_BITS-1:0] t,
  output logic                 fire
);

  localparam logic [TIME_BITS-1:0] T1 = TIME_BITS'(SW_T1);
  localparam logic [TIME_BITS-1:0] T2 = TIME_BITS'(SW_T2);
  localparam logic [TIME_BITS-1:0] T3 = TIME_BITS'(SW_T3);
  localparam logic [POS_BITS:0]    PW = (POS_BITS+1)'(PANEL_WIDTH);

  stage_t               wake_stage, wake_stage_next;
  stage_t               sleep_stage, sleep_stage_next;
  logic [TIME_BITS-1:0] start_time, start_time_next;

  logic [POS_BITS-1:0]  c, h;
  logic [TIME_BITS-1:0] dt;
  logic [POS_BITS:0]    sum1, sum2, sum3;
  logic                 wake_zone, sleep_zone;

  // Sleep boundaries are PANEL_WIDTH minus a position, so compare c + pos to the width.
  assign c    = cfg.swap_axes ? item.y_pos : item.x_pos;
  assign h    = cfg.swap_axes ? item.x_pos : item.y_pos;
  assign dt   = t - start_time;
  assign sum1 = {1'b0, c} + {1'b0, cfg.start_pos};
  assign sum2 = {1'b0, c} + {1'b0, cfg.mid_pos};
  assign sum3 = {1'b0, c} + {1'b0, cfg.end_pos};
  assign wake_zone  = item.screen_off && (cfg.sweep_mode != 2'd0) && (h > cfg.height_split);
  assign sleep_zone = !item.screen_off && cfg.sweep_mode[1] && (h < cfg.height_split);

  always_comb begin
    wake_stage_next  = wake_stage;
    sleep_stage_next = sleep_stage;
    start_time_next  = start_time;
    fire             = 1'b0;
    if (ctl.go) begin
      if (ctl.multi) begin
        wake_stage_next  = STAGE_IDLE;
        sleep_stage_next = STAGE_IDLE;
        start_time_next  = '0;
      end else if (item.cmd == CMD_SWIPE) begin
        if (wake_zone) begin
          if (c < cfg.start_pos) begin
            wake_stage_next = STAGE_ONE;
            start_time_next = t;
          end else if (wake_stage == STAGE_ONE && c > cfg.start_pos && dt < T1) begin
            wake_stage_next = STAGE_TWO;
          end else if (wake_stage == STAGE_TWO && c > cfg.mid_pos && dt < T2) begin
            wake_stage_next = STAGE_THREE;
          end else if (wake_stage == STAGE_THREE && c > cfg.end_pos && dt < T3) begin
            fire = 1'b1;
          end
        end else if (sleep_zone) begin
          if (sum1 > PW) begin
            sleep_stage_next = STAGE_ONE;
            start_time_next  = t;
          end else if (sleep_stage == STAGE_ONE && sum1 < PW && dt < T1) begin
            sleep_stage_next = STAGE_TWO;
          end else if (sleep_stage == STAGE_TWO && sum2 < PW && dt < T2) begin
            sleep_stage_next = STAGE_THREE;
          end else if (sleep_stage == STAGE_THREE && sum3 < PW && dt < T3) begin
            fire = 1'b1;
          end
        end
        if (fire) begin
          wake_stage_next  = STAGE_IDLE;
          sleep_stage_next = STAGE_IDLE;
          start_time_next  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wake_stage  <= STAGE_IDLE;
      sleep_stage <= STAGE_IDLE;
      start_time  <= '0;
    end else if (other_fire) begin
      wake_stage  <= STAGE_IDLE;
      sleep_stage <= STAGE_IDLE;
      start_time  <= '0;
    end else begin
      wake_stage  <= wake_stage_next;
      sleep_stage <= sleep_stage_next;
      start_time  <= start_time_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/tswk_tap.sv */
`default_nettype none
module tswk_tap
  import tswk_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_t                 ctl,
  input  logic                 other_fire,
  input  in_item_t             item,
  input  cfg_t                 cfg,
  input  logic [TIME_BITS-1:0] t,
  output logic                 fire
);

  localparam logic [TIME_BITS-1:0] SPAN   = TIME_BITS'(TAP_SPAN);
  localparam logic [TIME_BITS-1:0] GAP    = TIME_BITS'(TAP_MIN_GAP);
  localparam logic [TIME_BITS-1:0] WINDOW = TIME_BITS'(TAP_WINDOW);
  localparam logic [POS_BITS-1:0]  DELTA  = POS_BITS'(TAP_DELTA);
  localparam logic [POS_BITS-1:0]  LO     = POS_BITS'(TAP_LO);
  localparam logic [POS_BITS-1:0]  Y_HI   = POS_BITS'(TAP_Y_HI);
  localparam logic [POS_BITS-1:0]  X_HI   = POS_BITS'(TAP_X_HI);

  // The latest tap's time and position are kept, plus the first tap's time only.
  logic [TIME_BITS-1:0] last_time, last_time_next;
  logic [POS_BITS-1:0]  last_x, last_x_next;
  logic [POS_BITS-1:0]  last_y, last_y_next;
  logic [TIME_BITS-1:0] first_time, first_time_next;

  logic [TIME_BITS-1:0] span, gap;
  logic [POS_BITS-1:0]  dx, dy;
  logic                 in_box;

  assign span   = t - first_time;
  assign gap    = t - last_time;
  assign dx     = (item.x_pos >= last_x) ? item.x_pos - last_x : last_x - item.x_pos;
  assign dy     = (item.y_pos >= last_y) ? item.y_pos - last_y : last_y - item.y_pos;
  assign in_box = item.y_pos > LO && item.y_pos < Y_HI && item.x_pos > LO &&
                  item.x_pos < X_HI;

  always_comb begin
    last_time_next  = last_time;
    last_x_next     = last_x;
    last_y_next     = last_y;
    first_time_next = first_time;
    fire            = 1'b0;
    if (ctl.go && item.cmd == CMD_TAP) begin
      if (ctl.multi) begin
        last_time_next  = '0;
        last_x_next     = '0;
        last_y_next     = '0;
        first_time_next = '0;
      end else begin
        last_time_next = t;
        last_x_next    = item.x_pos;
        last_y_next    = item.y_pos;
        if (first_time == '0) begin
          first_time_next = t;
        end else if (span > SPAN) begin
          last_time_next  = '0;
          last_x_next     = '0;
          last_y_next     = '0;
          first_time_next = '0;
        end else if (gap >= GAP && item.screen_off && cfg.tap_enable) begin
          fire            = in_box && span < WINDOW && dx < DELTA && dy < DELTA;
          last_time_next  = '0;
          last_x_next     = '0;
          last_y_next     = '0;
          first_time_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time  <= '0;
      last_x     <= '0;
      last_y     <= '0;
      first_time <= '0;
    end else if (other_fire) begin
      last_time  <= '0;
      last_x     <= '0;
      last_y     <= '0;
      first_time <= '0;
    end else begin
      last_time  <= last_time_next;
      last_x     <= last_x_next;
      last_y     <= last_y_next;
      first_time <= first_time_next;
    end
  end

endmodule
`default_nettype wire
